// ===== src/dsfd_pkg.sv =====
// shared types and constants of the stuffed frame decoder
package dsfd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [7:0] SYM_START = 8'h55;
  localparam logic [7:0] SYM_END   = 8'h04;
  localparam logic [7:0] SYM_ESC   = 8'h05;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CSUM    = 2'd2;
  localparam logic [1:0] KIND_DROP    = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [8:0] position;
  } res_t;

endpackage

// ===== src/dle_stuffed_frame_decoder.sv =====
// top level of the byte-stuffed frame decoder with checksum check
//
//   channel  direction  ports                                     beat
//   in       input      in_rx_byte, in_chunk_end                  one serial byte
//   out      output     out_kind, out_data, out_position          zero or one per byte
//
// one byte is taken every cycle while in_stall is low; its result, if any, is written
// to the queue as the byte is taken, then moves on to the output register
// rst_n is synchronous; it returns the framing state to chunk start and empties the queue
// an output stall fills the two-entry queue; in_stall rises only when it is full
module dle_stuffed_frame_decoder import dsfd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_chunk_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic [8:0] out_position
);

  logic  q_push;
  logic  q_full;
  res_t  push_data;
  res_t  head;
  logic  pop;
  logic  not_empty;

  dsfd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_chunk_end (in_chunk_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  dsfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  dsfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (not_empty),
    .q_head       (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_position (out_position)
  );

endmodule

// ===== src/dsfd_front.sv =====
// front end: takes bytes, runs the framing state and classifies each beat
module dsfd_front import dsfd_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_chunk_end,
  input  logic       q_full,
  output logic       q_push,
  output res_t       q_data
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  localparam logic [1:0] PH_OPEN   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FRAME  = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  logic [1:0]       phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             emit;
  res_t             res;
  logic [CNT_W+8:0] cnt_ext;
  logic [8:0]       cnt_pos;
  logic             special;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_ext  = {9'd0, cnt_r};
  assign cnt_pos  = cnt_ext[8:0];
  assign special  = (in_rx_byte == SYM_START) || (in_rx_byte == SYM_END) ||
                    (in_rx_byte == SYM_ESC);

  always_comb begin
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    res.kind     = KIND_DROP;
    res.data     = 8'd0;
    res.position = 9'd0;
    unique case (phase_r)
      PH_OPEN: begin
        phase_nxt = (in_rx_byte == SYM_START) ? PH_SECOND : PH_IGNORE;
      end
      PH_SECOND: begin
        if (in_rx_byte == SYM_START) begin
          sum_nxt   = 8'd0;
          cnt_nxt   = '0;
          esc_nxt   = 1'b0;
          phase_nxt = PH_FRAME;
          emit      = in_chunk_end;
        end else begin
          phase_nxt = PH_IGNORE;
        end
      end
      PH_FRAME: begin
        priority if (!esc_r && cnt_r >= MAX_CNT) begin
          emit         = 1'b1;
          res.position = cnt_pos;
          phase_nxt    = PH_IGNORE;
        end else if (esc_r || !special) begin
          esc_nxt      = 1'b0;
          emit         = 1'b1;
          res.position = cnt_pos;
          if (!in_chunk_end) begin
            sum_nxt  = sum_r + in_rx_byte;
            res.kind = KIND_PAYLOAD;
            res.data = in_rx_byte;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end else if (in_rx_byte == SYM_START) begin
          sum_nxt = 8'd0;
          cnt_nxt = '0;
          emit    = in_chunk_end;
        end else if (in_rx_byte == SYM_END) begin
          emit         = 1'b1;
          res.kind     = (sum_r == 8'd0) ? KIND_GOOD : KIND_CSUM;
          res.position = cnt_pos;
          phase_nxt    = PH_IGNORE;
        end else begin
          if (in_chunk_end) begin
            emit         = 1'b1;
            res.position = cnt_pos;
          end else begin
            esc_nxt = 1'b1;
          end
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (in_chunk_end) begin
      phase_nxt = PH_OPEN;
      esc_nxt   = 1'b0;
      sum_nxt   = 8'd0;
      cnt_nxt   = '0;
    end
  end

  assign q_push = accept && emit;
  assign q_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      esc_r   <= 1'b0;
      sum_r   <= 8'd0;
      cnt_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/dsfd_queue.sv =====
// short result queue between front and back ends
module dsfd_queue import dsfd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  res_t  push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output res_t  head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST) ? '0 : rd_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/dsfd_back.sv =====
// back end: output register that hands results to the receiver
module dsfd_back import dsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  res_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic [8:0] out_position
);

  logic valid_r;
  res_t res_r;

  assign q_pop        = q_not_empty && (!valid_r || !out_stall);
  assign out_valid    = valid_r;
  assign out_kind     = res_r.kind;
  assign out_data     = res_r.data;
  assign out_position = res_r.position;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

endmodule
